@@ src/sbh_pkg.sv @@
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types and constants for the string bucket hash unit.
// ----------------------------------------------------------------------------
package sbh_pkg;

	// The bucket count saturates at 2**BUCKET_BITS.
	localparam int unsigned BUCKET_BITS = 16;

	localparam int unsigned HASH_W   = 32;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SIZE_W   = 17;
	localparam int unsigned BUCKET_W = 16;

	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 17'd1024;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	// Operands and operation handed to the shared adder.
	typedef struct packed {
		alu_op_t            op;
		logic [HASH_W-1:0]  a;
		logic [HASH_W-1:0]  b;
	} alu_req_t;

	// Result of the shared adder. For a subtraction, carry set means no borrow.
	typedef struct packed {
		logic               carry;
		logic [HASH_W-1:0]  sum;
	} alu_rsp_t;

endpackage

@@ src/sbh_alu.sv @@
// ----------------------------------------------------------------------------
// sbh_alu
// Shared 32-bit adder/subtractor used for every arithmetic step of the hash.
// ----------------------------------------------------------------------------
module sbh_alu (
	input  sbh_pkg::alu_req_t req,
	output sbh_pkg::alu_rsp_t rsp
);
	import sbh_pkg::*;

	logic [HASH_W-1:0] b_eff;
	logic              cin;

	always_comb begin
		case (req.op)
			ALU_ADD: begin
				b_eff = req.b;
				cin   = 1'b0;
			end
			ALU_SUB: begin
				b_eff = ~req.b;
				cin   = 1'b1;
			end
			default: begin
				b_eff = req.b;
				cin   = 1'b0;
			end
		endcase
	end

	assign {rsp.carry, rsp.sum} = {1'b0, req.a} + {1'b0, b_eff} + {{HASH_W{1'b0}}, cin};

endmodule

@@ src/sbh_seq.sv @@
// ----------------------------------------------------------------------------
// sbh_seq
// Sequencer and datapath registers: byte absorb, word fold, final mix and a
// bit-serial remainder, all stepping through the shared adder.
// ----------------------------------------------------------------------------
module sbh_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sbh_pkg::BYTE_W-1:0]    in_byte,
	input  logic                          in_last,
	input  logic [sbh_pkg::SIZE_W-1:0]    size,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sbh_pkg::BUCKET_W-1:0]  out_bucket,
	output logic [sbh_pkg::HASH_W-1:0]    out_hash
);
	import sbh_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_MIX1,
		ST_MIX2,
		ST_MIX3,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [HASH_W-1:0]     word_q;
	logic [1:0]            cnt_q;
	logic                  last_q;
	logic [HASH_W-1:0]     hash_q;
	logic [HASH_W-1:0]     acc_q;
	logic [BUCKET_W-1:0]   rem_q;
	logic [4:0]            step_q;
	logic                  out_valid_q;
	logic [BUCKET_W-1:0]   out_bucket_q;
	logic [HASH_W-1:0]     out_hash_q;

	alu_req_t              alu_req;
	alu_rsp_t              alu_rsp;
	logic [BUCKET_W:0]     trial;
	logic                  accept;
	logic                  load_out;

	sbh_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign load_out   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign trial      = {rem_q, acc_q[HASH_W-1]};
	assign out_valid  = out_valid_q;
	assign out_bucket = out_bucket_q;
	assign out_hash   = out_hash_q;

	always_comb begin
		alu_req.op = ALU_ADD;
		alu_req.a  = hash_q;
		alu_req.b  = hash_q >> 11;
		case (state_q)
			ST_IDLE: begin
				alu_req.a = word_q << 8;
				alu_req.b = {{(HASH_W-BYTE_W){in_byte[BYTE_W-1]}}, in_byte};
			end
			ST_FOLD: begin
				alu_req.a = hash_q;
				alu_req.b = word_q ^ (word_q >> 3);
			end
			ST_MIX1: begin
				alu_req.a = hash_q;
				alu_req.b = hash_q >> 11;
			end
			ST_MIX2: begin
				alu_req.a = acc_q;
				alu_req.b = hash_q >> 13;
			end
			ST_MIX3: begin
				alu_req.a = acc_q;
				alu_req.b = hash_q >> 23;
			end
			ST_DIV: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = {{(HASH_W-BUCKET_W-1){1'b0}}, trial};
				alu_req.b  = {{(HASH_W-SIZE_W){1'b0}}, size};
			end
			default: begin
				alu_req.op = ALU_ADD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			word_q       <= '0;
			cnt_q        <= '0;
			last_q       <= 1'b0;
			hash_q       <= '0;
			acc_q        <= '0;
			rem_q        <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			out_bucket_q <= '0;
			out_hash_q   <= '0;
		end else begin
			if (load_out) begin
				out_valid_q  <= 1'b1;
				out_bucket_q <= (size == '0) ? '0 : rem_q;
				out_hash_q   <= acc_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						word_q <= alu_rsp.sum;
						last_q <= in_last;
						if (in_last || (cnt_q == 2'd3)) begin
							state_q <= ST_FOLD;
						end else begin
							cnt_q <= cnt_q + 2'd1;
						end
					end
				end
				ST_FOLD: begin
					hash_q <= alu_rsp.sum;
					word_q <= '0;
					cnt_q  <= '0;
					state_q <= last_q ? ST_MIX1 : ST_IDLE;
				end
				ST_MIX1: begin
					acc_q   <= alu_rsp.sum;
					state_q <= ST_MIX2;
				end
				ST_MIX2: begin
					acc_q   <= alu_rsp.sum;
					state_q <= ST_MIX3;
				end
				ST_MIX3: begin
					acc_q   <= alu_rsp.sum;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// Restoring remainder, one dividend bit per cycle. The dividend
					// rotates so that it is whole again after the last step.
					rem_q  <= alu_rsp.carry ? alu_rsp.sum[BUCKET_W-1:0] : trial[BUCKET_W-1:0];
					acc_q  <= {acc_q[HASH_W-2:0], acc_q[HASH_W-1]};
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						hash_q  <= '0;
						last_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_rem_below_size: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (size != '0) |-> ({1'b0, rem_q} < size))
		else $error("remainder not below the table size");

	a_word_clear_at_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX1) |-> (word_q == '0) && (cnt_q == 2'd0))
		else $error("word not folded before the final mix");

	a_result_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && (state_q == ST_IDLE) && (hash_q == '0))
		else $error("result load did not clear the hash state");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD) |=> !((state_q == ST_DIV) && (step_q != 5'd0)))
		else $error("fold went straight into the remainder steps");

endmodule

@@ src/string_bucket_hash_unit.sv @@
// ----------------------------------------------------------------------------
// string_bucket_hash_unit
// Streaming string hash with bucket selection, one byte per beat.
// ----------------------------------------------------------------------------
//  channel  dir  width  contents
//  s_*      in   8+1    s_tdata = data_byte[7:0], s_tlast = last_byte
//  m_*      out  48     m_tdata = bucket_index[15:0], mixed_hash[47:16]
//  cfg_*    in   17     cfg_data = table_size
//
// A byte that is not last is absorbed in one adder step; one that completes a
// word also takes the fold step. A last byte passes through the absorb, the
// fold, three mix adds and one remainder step per dividend bit, all through the
// one shared adder, and then through the load of the output register.
// Reset clears the hash state and sets table_size to 1024.
// A finished result waits in the output register while the next string is
// absorbed; the block stalls at the end of that string until it is taken.
// ----------------------------------------------------------------------------
module string_bucket_hash_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [sbh_pkg::BYTE_W-1:0]      s_tdata,  // data_byte[7:0]
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [47:0]                     m_tdata,  // bucket_index[15:0], mixed_hash[47:16]
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sbh_pkg::SIZE_W-1:0]      cfg_data
);
	import sbh_pkg::*;

	localparam logic [HASH_W:0] BUCKET_LIMIT = {{HASH_W{1'b0}}, 1'b1} << BUCKET_BITS;

	logic [SIZE_W-1:0]   table_size_q;
	logic [HASH_W:0]     size_ext;
	logic [HASH_W:0]     size_sat;
	logic [BUCKET_W-1:0] bucket;
	logic [HASH_W-1:0]   hash;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= TABLE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			table_size_q <= cfg_data;
		end
	end

	// Sizes above the bucket limit saturate to it.
	assign size_ext = {{(HASH_W+1-SIZE_W){1'b0}}, table_size_q};
	assign size_sat = (size_ext > BUCKET_LIMIT) ? BUCKET_LIMIT : size_ext;

	sbh_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.size       (size_sat[SIZE_W-1:0]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_bucket (bucket),
		.out_hash   (hash)
	);

	assign m_tdata = {hash, bucket};

endmodule

@@ dv/string_bucket_hash_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_bucket_hash_unit_tb
// Streams strings byte by byte into the hash unit and checks every bucket
// index and mixed hash against a cycle-free software copy of the hash. The
// table size is changed between phases while the unit is idle. It covers
// zero, one, the full table and sizes beyond it. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module string_bucket_hash_unit_tb;
	import sbh_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_BYTES  = 225;
	localparam int unsigned BUCKET_LIMIT = 1 << BUCKET_BITS;

	typedef struct packed {
		logic              last;
		logic [BYTE_W-1:0] data;
	} str_byte_t;

	typedef struct packed {
		logic [HASH_W-1:0]   mixed;
		logic [BUCKET_W-1:0] bucket;
	} hash_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata = '0;  // data_byte[7:0]
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [47:0]       m_tdata;       // bucket_index[15:0], mixed_hash[47:16]
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data = '0;

	string_bucket_hash_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	str_byte_t    byte_queue[$];
	hash_result_t expected_hashes[$];
	int           bytes_sent = 0;
	int           bytes_taken = 0;
	int           errors = 0;
	int           cycle_count = 0;
	bit           quiet_phase = 1'b0;
	int           send_gap = 0;
	int           stall_left = 0;

	// Software copy of the hash state.
	logic [HASH_W-1:0] word_acc;
	logic [HASH_W-1:0] hash_sum;
	int                word_fill;
	logic [SIZE_W-1:0] bucket_count;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("string_bucket_hash_unit_tb NOT OK");
			$finish;
		end
	end

	// Mostly no gap, sometimes a short one, now and then a long one; none in the quiet phase.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet_phase || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void fold_word();
		hash_sum  = hash_sum + (word_acc ^ (word_acc >> 3));
		word_acc  = '0;
		word_fill = 0;
	endfunction

	function automatic void absorb_byte(input logic [BYTE_W-1:0] b, input logic last);
		logic [HASH_W-1:0] h;
		int unsigned       buckets;
		hash_result_t      res;
		word_acc = (word_acc << 8) + {{(HASH_W - BYTE_W){b[BYTE_W-1]}}, b};
		word_fill++;
		if (word_fill == 4)
			fold_word();
		if (last) begin
			fold_word();
			h = hash_sum;
			h = h + (h >> 11) + (h >> 13) + (h >> 23);
			buckets = (bucket_count > BUCKET_LIMIT) ? BUCKET_LIMIT : bucket_count;
			res.mixed  = h;
			res.bucket = (buckets == 0) ? '0 : BUCKET_W'(h % buckets);
			expected_hashes.push_back(res);
			hash_sum = '0;
		end
	endfunction

	// Sender: a new beat goes out once the previous one is taken and the gap is over.
	always @(posedge clk or negedge arst_n) begin : send_bytes
		str_byte_t beat;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (byte_queue.size() > 0) begin
				beat = byte_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= beat.data;
				s_tlast  <= beat.last;
				send_gap <= pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready   <= 1'b1;
			stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin : watch_ports
		hash_result_t due;
		if (arst_n) begin
			// Results are checked before this edge's byte is absorbed; a result
			// can never belong to a byte taken at the same edge.
			if (m_tvalid && m_tready) begin
				if (expected_hashes.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
				end else begin
					due = expected_hashes.pop_front();
					if (m_tdata[15:0] !== due.bucket) begin
						errors++;
						$display("%0t: bucket_index mismatch, expected %0d, got %0d",
							$time, due.bucket, m_tdata[15:0]);
					end
					if (m_tdata[47:16] !== due.mixed) begin
						errors++;
						$display("%0t: mixed_hash mismatch, expected %h, got %h",
							$time, due.mixed, m_tdata[47:16]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				absorb_byte(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (cfg_valid && cfg_ready)
				bucket_count = cfg_data;
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
		byte_queue.push_back('{last: last, data: b});
		bytes_sent++;
	endtask

	task automatic push_random_string();
		int               len;
		int               roll;
		logic [BYTE_W-1:0] b;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			len = $urandom_range(1, 8);
		else if (roll < 95)
			len = $urandom_range(9, 20);
		else
			len = $urandom_range(21, 64);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) < 2) begin
				case ($urandom_range(0, 3))
					0: b = 8'h00;
					1: b = 8'h7F;
					2: b = 8'h80;
					default: b = 8'hFF;
				endcase
			end else begin
				b = BYTE_W'($urandom);
			end
			push_byte(b, i == len - 1);
		end
	endtask

	// Every byte taken and every result back, then let the last string settle.
	task automatic wait_idle();
		while (bytes_taken != bytes_sent || expected_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_table_size(input logic [SIZE_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [SIZE_W-1:0] sizes[$];
		int                half;
		int                fill;
		word_acc     = '0;
		hash_sum     = '0;
		word_fill    = 0;
		bucket_count = TABLE_SIZE_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed strings under the reset table size: single bytes at the
		// sign boundary, an exact word, a word plus one, and two full words.
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h80, 1'b1);
		push_byte(8'h7F, 1'b1);
		push_byte(8'h80, 1'b0); push_byte(8'hFF, 1'b0);
		push_byte(8'h7F, 1'b0); push_byte(8'h01, 1'b1);
		push_byte(8'h41, 1'b0); push_byte(8'h42, 1'b0); push_byte(8'h43, 1'b0);
		push_byte(8'h44, 1'b0); push_byte(8'hC5, 1'b1);
		for (int i = 0; i < 8; i++)
			push_byte(8'hFF, i == 7);
		wait_idle();

		sizes = '{17'd1, 17'd65536, 17'd0, 17'd131071, 17'd65537, 17'd1023};
		sizes.push_back(SIZE_W'($urandom_range(2, 65535)));
		sizes.push_back(SIZE_W'($urandom));
		foreach (sizes[p]) begin
			quiet_phase = (p == 3);
			write_table_size(sizes[p]);
			half = bytes_sent + PHASE_BYTES / 2;
			fill = bytes_sent + PHASE_BYTES;
			while (bytes_sent < half)
				push_random_string();
			// On odd phases, hold the sender until every hash of the first half is back.
			if (p % 2 == 1)
				wait_idle();
			while (bytes_sent < fill)
				push_random_string();
			wait_idle();
		end

		if (errors == 0)
			$display("string_bucket_hash_unit_tb OK");
		else
			$display("string_bucket_hash_unit_tb NOT OK");
		$finish;
	end

endmodule
